@@ hdl/assert_macros.svh @@
// assertion macros shared by the receiver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define SFR_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never hold outside reset
`define SFR_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ hdl/sfr_pkg.sv @@
// types, constants and crc function for the serial frame receiver
package sfr_pkg;

  localparam logic [1:0] PH_HEAD_FIRST  = 2'd0;
  localparam logic [1:0] PH_HEAD_SECOND = 2'd1;
  localparam logic [1:0] PH_LENGTH      = 2'd2;
  localparam logic [1:0] PH_BODY        = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_SHORT      = 2'd1;
  localparam logic [1:0] ST_CRC        = 2'd2;
  localparam logic [1:0] ST_BAD_LENGTH = 2'd3;

  localparam logic [1:0] REG_CRC_ENABLE  = 2'd0;
  localparam logic [1:0] REG_HEAD_FIRST  = 2'd1;
  localparam logic [1:0] REG_HEAD_SECOND = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] HEAD_FIRST_RST  = 8'h5A;
  localparam logic [7:0] HEAD_SECOND_RST = 8'hA5;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       eq_first;
    logic       eq_second;
    logic       len_bad;
  } sfr_item_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic [7:0] body_position;
    logic       is_command;
    logic       is_payload;
    logic [7:0] payload_length;
    logic [7:0] command_code;
    logic       frame_end;
    logic [1:0] frame_status;
  } sfr_result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/sfr_front.sv @@
// front end: classifies received bytes and queues them for the parser
module sfr_front import sfr_pkg::*; #(
  parameter int MAX_BODY_BYTES = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_byte,
  input  logic [7:0] head_first,
  input  logic [7:0] head_second,
  output logic       deq_valid,
  output sfr_item_t  deq_item,
  input  logic       deq_pop
);

  localparam logic [7:0] MaxBody = 8'(MAX_BODY_BYTES);

  sfr_item_t  q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;
  sfr_item_t  item;

  always_comb begin
    item.data      = in_byte;
    item.eq_first  = (in_byte == head_first);
    item.eq_second = (in_byte == head_second);
    item.len_bad   = (in_byte == 8'd0) || (in_byte > MaxBody);
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign deq_valid = (count_r != 2'd0);
  assign pop       = deq_pop && deq_valid;
  assign deq_item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

@@ hdl/sfr_back.sv @@
// back end: header hunt, body tracking, crc check and result register
module sfr_back import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        crc_enable,
  input  logic        deq_valid,
  input  sfr_item_t   deq_item,
  output logic        deq_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output sfr_result_t out_result
);

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic        out_valid_r, out_valid_nxt;
  sfr_result_t res_r, res_nxt;
  logic        emit;
  logic        take;
  logic [8:0]  pos_p1, pos_p2;
  logic        last;
  logic [7:0]  b;

  assign take    = !out_valid_r || out_tready;
  assign deq_pop = deq_valid && take;
  assign b       = deq_item.data;
  assign pos_p1  = {1'b0, cnt_r} + 9'd1;
  assign pos_p2  = {1'b0, cnt_r} + 9'd2;
  assign last    = (pos_p1 >= {1'b0, len_r});

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    cmd_nxt    = cmd_r;
    emit       = 1'b0;
    res_nxt    = '0;
    if (deq_pop) begin
      unique case (phase_r)
        PH_HEAD_FIRST: begin
          if (deq_item.eq_first) begin
            phase_nxt = PH_HEAD_SECOND;
          end
        end
        PH_HEAD_SECOND: begin
          if (deq_item.eq_second) begin
            phase_nxt = PH_LENGTH;
          end else if (!deq_item.eq_first) begin
            phase_nxt = PH_HEAD_FIRST;
          end
        end
        PH_LENGTH: begin
          if (deq_item.len_bad) begin
            phase_nxt            = PH_HEAD_FIRST;
            len_nxt              = 8'd0;
            cnt_nxt              = 8'd0;
            emit                 = 1'b1;
            res_nxt.frame_end    = 1'b1;
            res_nxt.frame_status = ST_BAD_LENGTH;
          end else begin
            phase_nxt  = PH_BODY;
            len_nxt    = b;
            cnt_nxt    = 8'd0;
            crc_nxt    = CRC_INIT;
            crc_lo_nxt = 8'd0;
          end
        end
        PH_BODY: begin
          emit = 1'b1;
          if (cnt_r == 8'd0) begin
            cmd_nxt = b;
          end
          if (pos_p2 < {1'b0, len_r}) begin
            crc_nxt = crc16_byte(crc_r, b);
          end else if (pos_p2 == {1'b0, len_r}) begin
            crc_lo_nxt = b;
          end
          res_nxt.body_byte     = b;
          res_nxt.body_position = cnt_r;
          res_nxt.is_command    = (cnt_r == 8'd0);
          res_nxt.command_code  = cmd_nxt;
          res_nxt.frame_end     = last;
          if (crc_enable) begin
            res_nxt.is_payload     = (cnt_r != 8'd0) && (pos_p2 < {1'b0, len_r});
            res_nxt.payload_length = (len_r >= 8'd3) ? len_r - 8'd3 : 8'd0;
          end else begin
            res_nxt.is_payload     = (cnt_r != 8'd0);
            res_nxt.payload_length = (len_r >= 8'd1) ? len_r - 8'd1 : 8'd0;
          end
          if (last) begin
            if (crc_enable && len_r < 8'd3) begin
              res_nxt.frame_status = ST_SHORT;
            end else if (crc_enable && crc_r != {b, crc_lo_r}) begin
              res_nxt.frame_status = ST_CRC;
            end
            phase_nxt = PH_HEAD_FIRST;
            len_nxt   = 8'd0;
            cnt_nxt   = 8'd0;
          end else begin
            cnt_nxt = pos_p1[7:0];
          end
        end
        default: phase_nxt = PH_HEAD_FIRST;
      endcase
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEAD_FIRST;
      len_r       <= 8'd0;
      cnt_r       <= 8'd0;
      crc_r       <= CRC_INIT;
      crc_lo_r    <= 8'd0;
      cmd_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      crc_lo_r    <= crc_lo_nxt;
      cmd_r       <= cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_result = res_r;

endmodule

@@ hdl/serial_frame_receiver_crc16_top.sv @@
// top level of the serial frame receiver with crc-16 check
// a body byte enters the queue, then the result register that drives out_tvalid
// throughput: one byte per cycle while out_tready is high; a two-entry queue separates
// classification from parsing; header bytes and accepted length bytes give no request
// reset (synchronous, active low) empties the queue and result register and restores
// register defaults; no clearing pass is needed
`include "assert_macros.svh"

module serial_frame_receiver_crc16_top import sfr_pkg::*; #(
  parameter int MAX_BODY_BYTES = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // body_byte, body_position, payload_length,
                                  // command_code, frame_status, zero fill
  output logic [1:0]  out_tuser,  // is_command, is_payload
  output logic        out_tlast,  // frame_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic        crc_en_r;
  logic [7:0]  head_first_r;
  logic [7:0]  head_second_r;
  logic        deq_valid;
  logic        deq_pop;
  sfr_item_t   deq_item;
  sfr_result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_en_r      <= 1'b0;
      head_first_r  <= HEAD_FIRST_RST;
      head_second_r <= HEAD_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CRC_ENABLE:  crc_en_r      <= cfg_wdata[0];
        REG_HEAD_FIRST:  head_first_r  <= cfg_wdata;
        REG_HEAD_SECOND: head_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sfr_front #(
    .MAX_BODY_BYTES(MAX_BODY_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .head_first (head_first_r),
    .head_second(head_second_r),
    .deq_valid  (deq_valid),
    .deq_item   (deq_item),
    .deq_pop    (deq_pop)
  );

  sfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .crc_enable(crc_en_r),
    .deq_valid (deq_valid),
    .deq_item  (deq_item),
    .deq_pop   (deq_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_result(res)
  );

  assign out_tdata = {6'd0, res.frame_status, res.command_code, res.payload_length,
                      res.body_position, res.body_byte};
  assign out_tuser = {res.is_payload, res.is_command};
  assign out_tlast = res.frame_end;

  `SFR_ASSERT(a_status_only_at_end, clk, rst_n, out_tvalid && !out_tlast,
    out_tdata[33:32] == ST_OK, "status set on a byte that does not end a frame")
  `SFR_ASSERT(a_bad_length_zero, clk, rst_n,
    out_tvalid && out_tdata[33:32] == ST_BAD_LENGTH,
    out_tdata[31:0] == 32'd0 && out_tuser == 2'b00, "bad length result carries data")
  `SFR_ASSERT(a_command_at_zero, clk, rst_n, out_tvalid && out_tuser[0],
    out_tdata[15:8] == 8'd0 && !out_tuser[1], "command flag away from position zero")
  `SFR_NEVER(a_pop_empty, clk, rst_n, deq_pop && !deq_valid, "pop from empty queue")

endmodule
